// ----- design/sfr_pkg.sv -----
// ----------------------------------------------------------------------------
// sfr_pkg: shared types for the serial frame receiver
// Frame positions, status codes, register indexes and the structs passed
// between the parser and the top level.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned PayloadN = 4;

  typedef enum logic [2:0] {
    ST_WAIT      = 3'd0,
    ST_REJECT    = 3'd1,
    ST_OTHER     = 3'd2,
    ST_NORMAL    = 3'd3,
    ST_SPEAK_REQ = 3'd4,
    ST_SPEAK_END = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    POS_SYNC1 = 4'd0,
    POS_SYNC2 = 4'd1,
    POS_ADDR  = 4'd2,
    POS_FUNC  = 4'd3,
    POS_DATA0 = 4'd4,
    POS_DATA1 = 4'd5,
    POS_DATA2 = 4'd6,
    POS_DATA3 = 4'd7,
    POS_CHECK = 4'd8,
    POS_STOP  = 4'd9
  } pos_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SYNC_FIRST   = 3'd0,
    CFG_SYNC_SECOND  = 3'd1,
    CFG_STOP_VALUE   = 3'd2,
    CFG_OWN_ADDRESS  = 3'd3,
    CFG_CODE_NORMAL  = 3'd4,
    CFG_CODE_SPK_REQ = 3'd5,
    CFG_CODE_SPK_END = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [ByteW-1:0] sync_first;
    logic [ByteW-1:0] sync_second;
    logic [ByteW-1:0] stop_value;
    logic [ByteW-1:0] own_address;
    logic [ByteW-1:0] code_normal;
    logic [ByteW-1:0] code_speak_request;
    logic [ByteW-1:0] code_speak_end;
  } cfg_t;

  typedef struct packed {
    status_t                         status;
    logic [ByteW-1:0]                address;
    logic [ByteW-1:0]                func;
    logic [PayloadN-1:0][ByteW-1:0]  payload;
  } frame_result_t;

endpackage

// ----- design/serial_frame_receiver_addr_filter.sv -----
// ----------------------------------------------------------------------------
// serial_frame_receiver_addr_filter: framed byte receiver with address filter
// Parses ten-byte frames (two sync bytes, address, function, four data
// bytes, checksum, stop) and reports one status word for every byte.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one received byte per word (in_valid,
//   in_stall). Every accepted byte yields exactly one output word (out_valid,
//   out_stall) with a status code; frame fields are nonzero only on the
//   word for a good stop byte of a complete frame.
//   The word for an accepted byte is registered and shown from the next
//   cycle. Throughput is one byte per cycle while not stalled, set by the
//   single output register behind the per-byte compare and checksum add.
//   When the receiver stalls, the output word holds and in_stall rises only
//   while a word waits and out_stall is high; the register frees in the
//   same cycle it is taken, so back-to-back bytes flow without bubbles.
//   Reset clears all configuration registers to zero, drops out_valid and
//   sends the parser back to hunting for the first sync byte.
//   Write configuration through cfg_write/cfg_index/cfg_data only while
//   idle; indexes beyond the last register are ignored.
// ----------------------------------------------------------------------------
module serial_frame_receiver_addr_filter (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [sfr_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [sfr_pkg::ByteW-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [sfr_pkg::ByteW-1:0]     rx_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [2:0]                    status,
  output logic [sfr_pkg::ByteW-1:0]     frame_address,
  output logic [sfr_pkg::ByteW-1:0]     frame_function,
  output logic [sfr_pkg::ByteW-1:0]     payload_first,
  output logic [sfr_pkg::ByteW-1:0]     payload_second,
  output logic [sfr_pkg::ByteW-1:0]     payload_third,
  output logic [sfr_pkg::ByteW-1:0]     payload_fourth
);

  sfr_pkg::cfg_t cfg;
  sfr_pkg::frame_result_t result;
  sfr_pkg::frame_result_t out_word;
  logic accept;

  assign in_stall = out_valid && out_stall;
  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      unique case (sfr_pkg::cfg_idx_t'(cfg_index))
        sfr_pkg::CFG_SYNC_FIRST:   cfg.sync_first <= cfg_data;
        sfr_pkg::CFG_SYNC_SECOND:  cfg.sync_second <= cfg_data;
        sfr_pkg::CFG_STOP_VALUE:   cfg.stop_value <= cfg_data;
        sfr_pkg::CFG_OWN_ADDRESS:  cfg.own_address <= cfg_data;
        sfr_pkg::CFG_CODE_NORMAL:  cfg.code_normal <= cfg_data;
        sfr_pkg::CFG_CODE_SPK_REQ: cfg.code_speak_request <= cfg_data;
        sfr_pkg::CFG_CODE_SPK_END: cfg.code_speak_end <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  sfr_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .rx_byte (rx_byte),
    .cfg     (cfg),
    .result  (result)
  );

  // advance the output word on accept, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_word <= result;
    end
  end

  assign status = out_word.status;
  assign frame_address = out_word.address;
  assign frame_function = out_word.func;
  assign payload_first = out_word.payload[0];
  assign payload_second = out_word.payload[1];
  assign payload_third = out_word.payload[2];
  assign payload_fourth = out_word.payload[3];

  a_accept_gives_word: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted byte produced no output word");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= sfr_pkg::ST_SPEAK_END)
    else $error("status code out of range");

  a_idle_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == sfr_pkg::ST_WAIT)
      |-> (frame_address == '0 && frame_function == '0 &&
           payload_first == '0 && payload_second == '0 &&
           payload_third == '0 && payload_fourth == '0))
    else $error("waiting word carries frame fields");

  a_held_word_stable: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_word)))
    else $error("stalled output word changed");

endmodule

// ----- design/sfr_parser.sv -----
// ----------------------------------------------------------------------------
// sfr_parser: frame position tracker and checker
// Walks the ten byte positions of a frame, holds the frame bytes and the
// running checksum, and forms the word for each received byte.
// ----------------------------------------------------------------------------
module sfr_parser (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic [sfr_pkg::ByteW-1:0]   rx_byte,
  input  sfr_pkg::cfg_t               cfg,
  output sfr_pkg::frame_result_t      result
);

  sfr_pkg::pos_t pos;
  sfr_pkg::pos_t pos_next;
  logic [sfr_pkg::ByteW-1:0] running_sum;
  logic [sfr_pkg::ByteW-1:0] running_sum_next;
  logic [sfr_pkg::ByteW-1:0] held_address;
  logic [sfr_pkg::ByteW-1:0] held_function;
  logic [sfr_pkg::PayloadN-1:0][sfr_pkg::ByteW-1:0] held_payload;
  sfr_pkg::status_t frame_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= sfr_pkg::POS_SYNC1;
      running_sum <= '0;
    end else if (accept) begin
      pos <= pos_next;
      running_sum <= running_sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (pos == sfr_pkg::POS_ADDR) begin
        held_address <= rx_byte;
      end
      if (pos == sfr_pkg::POS_FUNC) begin
        held_function <= rx_byte;
      end
      if (pos == sfr_pkg::POS_DATA0 || pos == sfr_pkg::POS_DATA1 ||
          pos == sfr_pkg::POS_DATA2 || pos == sfr_pkg::POS_DATA3) begin
        held_payload[pos[1:0]] <= rx_byte;
      end
    end
  end

  always_comb begin
    if (held_address != cfg.own_address) begin
      frame_status = sfr_pkg::ST_OTHER;
    end else if (held_function == cfg.code_normal) begin
      frame_status = sfr_pkg::ST_NORMAL;
    end else if (held_function == cfg.code_speak_request) begin
      frame_status = sfr_pkg::ST_SPEAK_REQ;
    end else if (held_function == cfg.code_speak_end) begin
      frame_status = sfr_pkg::ST_SPEAK_END;
    end else begin
      frame_status = sfr_pkg::ST_REJECT;
    end
  end

  always_comb begin
    pos_next = pos;
    running_sum_next = running_sum;
    result = '0;
    result.status = sfr_pkg::ST_WAIT;
    unique case (pos)
      sfr_pkg::POS_SYNC1: begin
        if (rx_byte == cfg.sync_first) begin
          pos_next = sfr_pkg::POS_SYNC2;
        end else begin
          result.status = sfr_pkg::ST_REJECT;
        end
      end
      sfr_pkg::POS_SYNC2: begin
        if (rx_byte == cfg.sync_second) begin
          pos_next = sfr_pkg::POS_ADDR;
        end else begin
          pos_next = sfr_pkg::POS_SYNC1;
          result.status = sfr_pkg::ST_REJECT;
        end
      end
      sfr_pkg::POS_ADDR: begin
        running_sum_next = rx_byte;
        pos_next = sfr_pkg::POS_FUNC;
      end
      sfr_pkg::POS_FUNC: begin
        running_sum_next = running_sum + rx_byte;
        pos_next = sfr_pkg::POS_DATA0;
      end
      sfr_pkg::POS_DATA0: begin
        running_sum_next = running_sum + rx_byte;
        pos_next = sfr_pkg::POS_DATA1;
      end
      sfr_pkg::POS_DATA1: begin
        running_sum_next = running_sum + rx_byte;
        pos_next = sfr_pkg::POS_DATA2;
      end
      sfr_pkg::POS_DATA2: begin
        running_sum_next = running_sum + rx_byte;
        pos_next = sfr_pkg::POS_DATA3;
      end
      sfr_pkg::POS_DATA3: begin
        running_sum_next = running_sum + rx_byte;
        pos_next = sfr_pkg::POS_CHECK;
      end
      sfr_pkg::POS_CHECK: begin
        if (running_sum == rx_byte) begin
          pos_next = sfr_pkg::POS_STOP;
        end else begin
          pos_next = sfr_pkg::POS_SYNC1;
          result.status = sfr_pkg::ST_REJECT;
        end
      end
      sfr_pkg::POS_STOP: begin
        pos_next = sfr_pkg::POS_SYNC1;
        if (rx_byte == cfg.stop_value) begin
          result.status = frame_status;
          result.address = held_address;
          result.func = held_function;
          result.payload = held_payload;
        end else begin
          result.status = sfr_pkg::ST_REJECT;
        end
      end
      default: begin
        pos_next = sfr_pkg::POS_SYNC1;
      end
    endcase
  end

  a_stop_returns_to_hunt: assert property (@(posedge clk) disable iff (rst)
    (accept && pos == sfr_pkg::POS_STOP) |=> pos == sfr_pkg::POS_SYNC1)
    else $error("parser did not return to hunting after stop position");

  a_check_fail_hunts: assert property (@(posedge clk) disable iff (rst)
    (accept && pos == sfr_pkg::POS_CHECK && running_sum != rx_byte)
      |=> pos == sfr_pkg::POS_SYNC1)
    else $error("checksum mismatch did not restart the hunt");

  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    pos <= sfr_pkg::POS_STOP)
    else $error("frame position left the valid range");

endmodule
